// ===== hw/rtl/spe_pkg.sv =====
// Shared types and constants of the shifted polynomial evaluator.
package spe_pkg;

  localparam int unsigned QW      = 32;
  localparam int unsigned FRAC    = 16;
  localparam int unsigned NCOEF   = 6;
  localparam int unsigned DEG_W   = 3;
  localparam int unsigned PROD_W  = 2 * QW;
  localparam int unsigned SHIFT_W = PROD_W - FRAC;

  localparam logic [DEG_W-1:0] DEG_MIN = DEG_W'(1);
  localparam logic [DEG_W-1:0] DEG_MAX = DEG_W'(5);

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef logic signed [QW-1:0] q_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DONE
  } state_t;

  typedef struct packed {
    q_t   sum;
    logic ovf;
  } mac_res_t;

  // Clamp a 33-bit sum to 32 bits; report whether clamping happened.
  function automatic mac_res_t sat33(input logic signed [QW:0] v);
    mac_res_t r;
    r.ovf = (v[QW] != v[QW-1]);
    if (!r.ovf) begin
      r.sum = v[QW-1:0];
    end else if (v[QW]) begin
      r.sum = Q_MIN;
    end else begin
      r.sum = Q_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/spe_mac.sv =====
// Shared multiply-accumulate unit: registered product, then shift, clamp, add, clamp.
module spe_mac
  import spe_pkg::*;
(
  input  logic     clk,
  input  logic     mul_en,
  input  q_t       mul_a,
  input  q_t       mul_b,
  input  q_t       addend,
  output mac_res_t res
);

  logic signed [PROD_W-1:0]  prod;
  logic signed [SHIFT_W-1:0] shifted;
  logic                      prod_ovf;
  q_t                        prod_sat;
  mac_res_t                  add_res;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
  end

  always_comb begin
    // arithmetic shift right drops the fraction bits (floor)
    shifted  = prod[PROD_W-1:FRAC];
    prod_ovf = (shifted[SHIFT_W-1:QW-1] != {(SHIFT_W-QW+1){1'b0}}) &&
               (shifted[SHIFT_W-1:QW-1] != {(SHIFT_W-QW+1){1'b1}});
    if (!prod_ovf) begin
      prod_sat = shifted[QW-1:0];
    end else if (shifted[SHIFT_W-1]) begin
      prod_sat = Q_MIN;
    end else begin
      prod_sat = Q_MAX;
    end
    add_res = sat33({prod_sat[QW-1], prod_sat} + {addend[QW-1], addend});
    res.sum = add_res.sum;
    res.ovf = add_res.ovf | prod_ovf;
  end

endmodule

// ===== hw/rtl/shifted_polynomial_eval_top.sv =====
// Top level of the shifted polynomial evaluator (Horner's rule, Q16.16).
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request: degree,
//   point, origin and coef0..coef5, all signed Q16.16 but degree. The block
//   forms d = point - origin, clamped to 32 bits, then runs Horner's rule
//   from the top coefficient down on one shared multiply-accumulate unit.
//   Each step first registers the 32x32 product, then shifts, clamps,
//   adds the next coefficient and clamps again.
//   The output channel (out_valid/out_ready) returns value and overflow.
// Occupancy:
//   With the degree clamped to 1..5, in_ready stays low from the
//   accepting edge until the result enters the output register, so
//   no new request is taken before the last one is through. The
//   step of the shared multiplier, multiply then add, sets the pace.
// Stall:
//   The result sits in an output register; a new request is taken while
//   it waits. If the next result is done before the receiver takes the
//   old one, hold it in the finishing state until the register frees.
// Reset:
//   rst is synchronous and active high; it drops any request in flight
//   and clears out_valid. No clearing pass is needed.
module shifted_polynomial_eval_top
  import spe_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [DEG_W-1:0] degree,
  input  q_t               point,
  input  q_t               origin,
  input  q_t               coef0,
  input  q_t               coef1,
  input  q_t               coef2,
  input  q_t               coef3,
  input  q_t               coef4,
  input  q_t               coef5,
  output logic             out_valid,
  input  logic             out_ready,
  output q_t               value,
  output logic             overflow
);

  state_t           state, state_next;
  q_t               coefs [NCOEF];
  q_t               d;
  q_t               acc;
  logic             ovf;
  logic [DEG_W-1:0] k;
  logic [DEG_W-1:0] deg_in;
  q_t               top_coef;
  mac_res_t         diff;
  mac_res_t         mac;
  logic             accept;
  logic             mul_en;
  logic             out_load;

  // Clamp the requested degree into 1..5.
  always_comb begin
    if (degree < DEG_MIN) begin
      deg_in = DEG_MIN;
    end else if (degree > DEG_MAX) begin
      deg_in = DEG_MAX;
    end else begin
      deg_in = degree;
    end
  end

  // Horner starts from the coefficient at the degree.
  always_comb begin
    case (deg_in)
      3'd1:    top_coef = coef1;
      3'd2:    top_coef = coef2;
      3'd3:    top_coef = coef3;
      3'd4:    top_coef = coef4;
      default: top_coef = coef5;
    endcase
  end

  // Shifted point, clamped; set overflow if clamped.
  assign diff = sat33({point[QW-1], point} - {origin[QW-1], origin});

  spe_mac u_mac (
    .clk    (clk),
    .mul_en (mul_en),
    .mul_a  (acc),
    .mul_b  (d),
    .addend (coefs[k]),
    .res    (mac)
  );

  // Sequencer: next state and strobes.
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_en     = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        mul_en     = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        state_next = (k == '0) ? S_DONE : S_MUL;
      end
      S_DONE: begin
        // hold the result until the output register frees
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers: latch the request, then advance one Horner step.
  always_ff @(posedge clk) begin
    if (accept) begin
      coefs[0] <= coef0;
      coefs[1] <= coef1;
      coefs[2] <= coef2;
      coefs[3] <= coef3;
      coefs[4] <= coef4;
      coefs[5] <= coef5;
      d        <= diff.sum;
      ovf      <= diff.ovf;
      acc      <= top_coef;
      k        <= deg_in - DEG_W'(1);
    end else if (state == S_ADD) begin
      acc <= mac.sum;
      ovf <= ovf | mac.ovf;
      if (k != '0) begin
        k <= k - DEG_W'(1);
      end
    end
  end

  // Output register: load the finished result, drop it once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      value    <= acc;
      overflow <= ovf;
    end
  end

endmodule

// ===== hw/rtl/spe_checker.sv =====
// Port-level checker of the shifted polynomial evaluator, bound to the top level.
module spe_checker
  import spe_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input q_t               value,
  input logic             overflow
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(value) && $stable(overflow))
    else $error("stalled result changed");

  // Every request keeps the block busy for at least one Horner step.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("block ready too soon after a request");

  // A new result only appears at the end of work, never from idle.
  a_res_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");

  // The block returns to ready right after delivering a new result.
  a_ready_after: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("block not ready after loading a result");

endmodule

bind shifted_polynomial_eval_top spe_checker u_spe_checker (.*);

// ===== tb/sv/shifted_polynomial_eval_top_test.sv =====
// Self-checking testbench of the shifted polynomial evaluator: table-driven and random requests.
`timescale 1ns / 100ps

module shifted_polynomial_eval_top_test;
  import spe_pkg::*;

  // One request as the sender offers it, and one result as the block returns it.
  typedef struct packed {
    logic [DEG_W-1:0]            deg;
    q_t                          point;
    q_t                          origin;
    logic [NCOEF-1:0][QW-1:0]    coef;
  } poly_req_t;

  typedef struct packed {
    q_t   val;
    logic ovf;
  } poly_res_t;

  // A row of the directed table; fixed_res is used instead of the predictor when fixed is set.
  typedef struct {
    poly_req_t req;
    bit        fixed;
    poly_res_t fixed_res;
  } dir_row_t;

  localparam int N_ITEMS    = 1150;
  localparam int SQUEEZE_AT = 400;    // request count at which the receiver holds off
  localparam int SQUEEZE_CY = 200;    // length of that hold-off in cycles
  localparam int DRAIN_CY   = 30;     // idle time after the last owed result, in cycles
  localparam int WDOG_LIMIT = 2000;   // cycles with no handshake on either side
  localparam int MAX_SHOWN  = 10;

  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [DEG_W-1:0] degree;
  q_t               point;
  q_t               origin;
  q_t               coef0;
  q_t               coef1;
  q_t               coef2;
  q_t               coef3;
  q_t               coef4;
  q_t               coef5;
  logic             out_valid;
  logic             out_ready;
  q_t               value;
  logic             overflow;

  shifted_polynomial_eval_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .degree    (degree),
    .point     (point),
    .origin    (origin),
    .coef0     (coef0),
    .coef1     (coef1),
    .coef2     (coef2),
    .coef3     (coef3),
    .coef4     (coef4),
    .coef5     (coef5),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .overflow  (overflow)
  );

  // Results still owed by the block, oldest first.
  poly_res_t pending_evals[$];
  dir_row_t  dir_tab[$];

  int  n_sent;
  int  n_checked;
  int  n_ovf_seen;
  int  n_bad;
  int  idle_cycles;
  bit  squeeze;
  int  tx_calm;
  int  rx_calm;

  // Clamp to the signed 32-bit range.
  function automatic longint clip_q(input longint v);
    if (v > Q_HI) return Q_HI;
    if (v < Q_LO) return Q_LO;
    return v;
  endfunction

  // Evaluate one request by Horner's rule on the shifted point.
  function automatic poly_res_t eval_poly(input poly_req_t r);
    int unsigned n;
    longint      d;
    longint      acc;
    longint      p;
    longint      s;
    bit          sat;
    poly_res_t   res;
    n = r.deg;
    if (n < 1) n = 1;
    if (n > 5) n = 5;
    sat = 1'b0;
    s = longint'(r.point) - longint'(r.origin);
    d = clip_q(s);
    sat |= (d != s);
    acc = longint'($signed(r.coef[n]));
    for (int k = int'(n) - 1; k >= 0; k--) begin
      // Floor shift of the exact product, then clamp, add and clamp again.
      p = (acc * d) >>> FRAC;
      s = clip_q(p);
      sat |= (s != p);
      p = s + longint'($signed(r.coef[k]));
      acc = clip_q(p);
      sat |= (acc != p);
    end
    res.val = q_t'(acc);
    res.ovf = sat;
    return res;
  endfunction

  // Draw an idle stretch: mostly none or short, a few long, with calm bursts of none.
  task automatic draw_gap(inout int calm, output int gap);
    int pick;
    pick = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if (pick < 5) begin
      calm = $urandom_range(20, 40);
      gap = 0;
    end else if (pick < 50) begin
      gap = 0;
    end else if (pick < 85) begin
      gap = $urandom_range(1, 3);
    end else if (pick < 97) begin
      gap = $urandom_range(4, 10);
    end else begin
      gap = $urandom_range(20, 60);
    end
  endtask

  // Random Q16.16 operand: mostly small magnitudes so Horner chains stay in range,
  // some medium, some fully random and some corner values.
  function automatic q_t rand_q();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return q_t'(int'($urandom_range(0, 524288)) - 262144);
    if (pick < 70) return q_t'(int'($urandom_range(0, 33554432)) - 16777216);
    if (pick < 88) return q_t'($urandom);
    case ($urandom_range(0, 6))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return q_t'(0);
      3: return q_t'(1);
      4: return q_t'(-1);
      5: return q_t'(32'sh0001_0000);
      default: return q_t'(-32'sh0001_0000);
    endcase
  endfunction

  task automatic add_row(input logic [DEG_W-1:0] dg, input q_t pt, input q_t org,
                         input q_t c0, input q_t c1, input q_t c2, input q_t c3,
                         input q_t c4, input q_t c5, input bit fx, input q_t v,
                         input logic o);
    dir_row_t row;
    row.req.deg       = dg;
    row.req.point     = pt;
    row.req.origin    = org;
    row.req.coef      = {c5, c4, c3, c2, c1, c0};
    row.fixed         = fx;
    row.fixed_res.val = v;
    row.fixed_res.ovf = o;
    dir_tab.push_back(row);
  endtask

  // Present one request at the falling edge and hold it until the block takes it.
  task automatic offer(input poly_req_t r);
    @(negedge clk);
    in_valid = 1'b1;
    degree   = r.deg;
    point    = r.point;
    origin   = r.origin;
    coef0    = r.coef[0];
    coef1    = r.coef[1];
    coef2    = r.coef[2];
    coef3    = r.coef[3];
    coef4    = r.coef[4];
    coef5    = r.coef[5];
    do @(posedge clk); while (!in_ready);
    n_sent++;
  endtask

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sender: hold reset, walk the directed table, then random requests.
  initial begin
    poly_req_t r;
    int        gap;
    in_valid  = 1'b0;
    degree    = '0;
    point     = '0;
    origin    = '0;
    coef0     = '0;
    coef1     = '0;
    coef2     = '0;
    coef3     = '0;
    coef4     = '0;
    coef5     = '0;
    rst       = 1'b1;
    squeeze   = 1'b0;
    tx_calm   = 0;
    n_sent    = 0;

    // Directed rows with a typed expectation use only zero shifts or one-step chains.
    // Degree one at d = 0: value is the constant term.
    add_row(3'd1, 0, 0, 32'sh0001_0000, Q_MAX, 0, 0, 0, 0, 1, 32'sh0001_0000, 0);
    // Degree five at d = 0: every product vanishes, coefficients at the extremes.
    add_row(3'd5, 0, 0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1, Q_MIN, 0);
    // Degree zero behaves as degree one.
    add_row(3'd0, 0, 0, 123, Q_MIN, Q_MAX, 0, 0, 0, 1, 123, 0);
    // Degree seven behaves as degree five.
    add_row(3'd7, 0, 0, -1, 5, 6, 7, 8, 9, 1, -1, 0);
    // Subtraction saturates high and low.
    add_row(3'd1, Q_MAX, Q_MIN, 0, 0, 0, 0, 0, 0, 1, 0, 1);
    add_row(3'd1, Q_MIN, 1, 7, 0, 0, 0, 0, 0, 1, 7, 1);
    // Product saturates although the sum lands in range.
    add_row(3'd1, Q_MAX, 0, Q_MIN, Q_MAX, 0, 0, 0, 0, 1, -1, 1);
    // Sum saturates: max times one plus one lsb.
    add_row(3'd1, 32'sh0001_0000, 0, 1, Q_MAX, 0, 0, 0, 0, 1, Q_MAX, 1);
    // Plain arithmetic: 3.0 + 2.0 * 1.0.
    add_row(3'd1, 32'sh0001_0000, 0, 32'sh0003_0000, 32'sh0002_0000, 0, 0, 0, 0,
            1, 32'sh0005_0000, 0);
    // Negative product rounds toward minus infinity: one lsb times minus one lsb.
    add_row(3'd1, -1, 0, 0, 1, 0, 0, 0, 0, 1, -1, 0);
    // The rest go through the predictor.
    add_row(3'd2, 32'sh0001_8000, 32'shFFFF_0000, 32'sh0000_4000, -32'sh0002_0000,
            32'sh0000_C000, Q_MAX, Q_MIN, 0, 0, 0, 0);
    add_row(3'd3, -32'sh0000_8000, 32'sh0000_4000, 32'sh0001_0000, 32'sh0002_0000,
            -32'sh0003_0000, 32'sh0004_0000, 0, 0, 0, 0, 0);
    add_row(3'd4, 32'sh0002_0000, 32'sh0003_8000, -32'sh0000_0100, 32'sh0000_1234,
            32'sh0001_5678, -32'sh0000_9ABC, 32'sh0000_7FFF, 0, 0, 0, 0);
    add_row(3'd5, 32'sh0000_F000, -32'sh0000_1000, 32'sh0001_0000, -32'sh0001_0000,
            32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000, 0, 0, 0);
    add_row(3'd5, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0);
    add_row(3'd5, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0);
    add_row(3'd6, -32'sh0001_4000, 0, 32'sh0000_2000, 32'sh0000_3000, 32'sh0000_4000,
            32'sh0000_5000, 32'sh0000_6000, 32'sh0000_7000, 0, 0, 0);
    add_row(3'd2, 32'sh00C8_0000, 0, 0, 0, 32'sh0000_0100, 0, 0, 0, 0, 0, 0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < N_ITEMS; i++) begin
      if (i < dir_tab.size()) begin
        r = dir_tab[i].req;
      end else begin
        r.deg = ($urandom_range(0, 99) < 85) ? DEG_W'($urandom_range(1, 5))
                                              : DEG_W'($urandom_range(0, 7));
        // Points near the origin keep the chain alive; the rest roam the full range.
        r.origin = rand_q();
        if ($urandom_range(0, 3) == 0) begin
          r.point = rand_q();
        end else begin
          r.point = r.origin + q_t'(int'($urandom_range(0, 262144)) - 131072);
        end
        for (int k = 0; k < NCOEF; k++) r.coef[k] = rand_q();
      end
      offer(r);
      // Record what the accepted request owes.
      if (i < dir_tab.size() && dir_tab[i].fixed) begin
        pending_evals.push_back(dir_tab[i].fixed_res);
      end else begin
        pending_evals.push_back(eval_poly(r));
      end
      if (n_sent == SQUEEZE_AT) squeeze = 1'b1;
      draw_gap(tx_calm, gap);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;

    // Drain: wait for every owed result, then give the block time to misbehave.
    while (pending_evals.size() != 0) @(posedge clk);
    repeat (DRAIN_CY) @(posedge clk);

    $display("Ran %0d requests (%0d from the table, degrees 0..7, saturating and clean chains).",
             n_sent, dir_tab.size());
    $display("Checked %0d results, %0d flagged overflow; one long output stall backed up the input.",
             n_checked, n_ovf_seen);
    if (n_bad == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Receiver: toggle out_ready at the falling edge; hold off once for a long stretch.
  initial begin
    int gap;
    out_ready = 1'b0;
    rx_calm   = 0;
    gap       = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (squeeze) begin
        squeeze   = 1'b0;
        out_ready = 1'b0;
        repeat (SQUEEZE_CY) @(negedge clk);
      end
      if (gap > 0) begin
        out_ready = 1'b0;
        gap--;
      end else begin
        out_ready = 1'b1;
        draw_gap(rx_calm, gap);
      end
    end
  end

  // Compare every accepted result with the oldest owed one.
  always @(posedge clk) begin
    poly_res_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_evals.size() == 0) begin
        if (n_bad < MAX_SHOWN)
          $display("%0t: result %h/%0b with no request outstanding", $realtime, value, overflow);
        n_bad++;
      end else begin
        want = pending_evals.pop_front();
        n_checked++;
        if (overflow) n_ovf_seen++;
        if (value !== want.val || overflow !== want.ovf) begin
          if (n_bad < MAX_SHOWN)
            $display("%0t: result %0d: value %h ovf %0b, expected value %h ovf %0b",
                     $realtime, n_checked, value, overflow, want.val, want.ovf);
          n_bad++;
        end
      end
    end
  end

  // Watchdog: abort if neither side completes a handshake for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("Timeout: %0d cycles with no handshake, %0d results owed",
               idle_cycles, pending_evals.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    n_checked   = 0;
    n_ovf_seen  = 0;
    n_bad       = 0;
    idle_cycles = 0;
  end

endmodule
